// ----- src/cfla_pkg.sv -----
// Package for the chunked free-list allocator: shared widths, codes,
// reset values and the controller/datapath command and status types.
// No dependencies.
package cfla_pkg;

    localparam int DEF_MAX_CHUNKS = 8;
    localparam int DEF_SLOTS      = 8192;

    localparam int IB_W = 17;   // item_bytes
    localparam int CB_W = 19;   // chunk_bytes, also span
    localparam int OP_W = 3;

    localparam logic [IB_W-1:0] ITEM_RST  = IB_W'(16);
    localparam logic [CB_W-1:0] CHUNK_RST = CB_W'(32 * 1024);
    localparam logic [IB_W-1:0] ITEM_MIN  = IB_W'(4);

    localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE     = 3'd1;
    localparam logic [OP_W-1:0] OP_OWNER    = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE_ALL = 3'd3;
    localparam logic [OP_W-1:0] OP_DRAIN    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_OWN  = 2'd2;
    localparam logic [1:0] ST_MISALIGN = 2'd3;

    typedef enum logic [4:0] {
        C_NONE,
        C_GEOM_START,
        C_GEOM_N,
        C_GEOM_SPAN,
        C_ACCEPT,
        C_HEAD_RD,
        C_SCAN_NEXT,
        C_FULL,
        C_LINK,
        C_POP_LK,
        C_POP_WR,
        C_TOTAL,
        C_OWNED,
        C_NOTOWN,
        C_DIV_OFF,
        C_MISAL,
        C_FREE_WR,
        C_DRAIN,
        C_OUT
    } cmd_t;

    typedef struct packed {
        logic            dirty;
        logic            div_done;
        logic            cnt_eq;
        logic            head_free;
        logic            can_new;
        logic            slot_last;
        logic            in_pool;
        logic            above;
        logic            rem_zero;
        logic            out_free;
        logic [OP_W-1:0] op;
    } dp_sts_t;

endpackage

// ----- src/chunked_free_list_allocator.sv -----
// Chunked free-list allocator, top level. Alloc scans each full chunk and may
// link a new chunk of S slots. Free skips the chunks below the address and
// uses the divider. Owner, drain and free-all (which relinks every chunk) are
// the other operations. One item at a time; the next is accepted while a
// result waits in m_tdata.
// Reset is synchronous; reset and each config write recompute geometry.
module chunked_free_list_allocator #(
    parameter int MAX_CHUNKS = cfla_pkg::DEF_MAX_CHUNKS,
    parameter int SLOTS      = cfla_pkg::DEF_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[2:0], address[34:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // slot_address[31:0], owned[32], status[34:33]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cfla_pkg::*;

    cmd_t    cmd;
    dp_sts_t sts;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    cfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfla_dp #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .SLOTS      (SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_wr    (cfg_wr),
        .cfg_sel   (paddr[2]),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- src/cfla_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on cfla_pkg.
module cfla_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cfla_pkg::CB_W-1:0] dividend,
    input  logic [cfla_pkg::IB_W-1:0] divisor,
    output logic                      done,
    output logic [cfla_pkg::CB_W-1:0] quo,
    output logic [cfla_pkg::IB_W-1:0] rem
);
    import cfla_pkg::*;

    localparam int CNT_W = $clog2(CB_W + 1);

    logic [CB_W-1:0]  quo_reg;
    logic [IB_W-1:0]  rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [IB_W:0]    trial;
    logic             ge;

    assign trial = {rem_reg, quo_reg[CB_W-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(CB_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? IB_W'(trial - {1'b0, divisor}) : trial[IB_W-1:0];
            quo_reg <= {quo_reg[CB_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("divider done held");
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> done_reg) else $error("divider ended without done");

endmodule

// ----- src/cfla_dp.sv -----
// Allocator datapath: config registers, geometry, head and link memories,
// counters and output register. Depends on cfla_pkg and cfla_div.
module cfla_dp #(
    parameter int MAX_CHUNKS = cfla_pkg::DEF_MAX_CHUNKS,
    parameter int SLOTS      = cfla_pkg::DEF_SLOTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfla_pkg::cmd_t        cmd,
    output cfla_pkg::dp_sts_t     sts,
    input  logic [39:0]           s_tdata,
    input  logic                  cfg_wr,
    input  logic                  cfg_sel,
    input  logic [31:0]           cfg_wdata,
    output logic [31:0]           cfg_rdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata
);
    import cfla_pkg::*;

    localparam int CNW = $clog2(MAX_CHUNKS + 1);
    localparam int CW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int LW  = $clog2(SLOTS + 1);
    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW  = CW + IW;
    localparam int TW  = CB_W + CNW;

    logic [IB_W-1:0] item_reg;
    logic [CB_W-1:0] chunk_reg;
    logic            dirty_reg;
    logic [LW-1:0]   n_reg;
    logic [CB_W-1:0] span_reg;
    logic [TW-1:0]   total_reg;
    logic [CNW-1:0]  chunks_reg;
    logic [CNW-1:0]  cnt_reg;
    logic [TW-1:0]   base_reg;
    logic [LW-1:0]   slot_reg;
    logic [OP_W-1:0] op_reg;
    logic [31:0]     addr_reg;
    logic [LW-1:0]   head_q;
    logic [LW-1:0]   link_q;
    logic [IW+IB_W-1:0] prod_reg;
    logic [31:0]     res_addr_reg;
    logic            owned_reg;
    logic [1:0]      status_reg;
    logic            m_valid_reg;
    logic [39:0]     m_data_reg;

    logic [LW-1:0]   head_mem [MAX_CHUNKS];
    logic [LW-1:0]   link_mem [2**AW];

    logic [IB_W-1:0] isz;
    logic [CW-1:0]   cidx;
    logic            slot_last;
    logic [LW-1:0]   slot_inc;
    logic [TW:0]     base_span;
    logic            div_start;
    logic [CB_W-1:0] div_dividend;
    logic            div_done;
    logic [CB_W-1:0] div_quo;
    logic [IB_W-1:0] div_rem;
    logic [33:0]     res_sum;
    logic [2*IB_W-1:0] span_prod;

    assign isz       = (item_reg < ITEM_MIN) ? ITEM_MIN : item_reg;
    assign cidx      = cnt_reg[CW-1:0];
    assign slot_inc  = slot_reg + 1'b1;
    assign slot_last = slot_inc == n_reg;
    assign base_span = {1'b0, base_reg} + (TW+1)'(span_reg);
    assign res_sum   = 34'(base_reg) + 34'(prod_reg);
    assign span_prod = (2*IB_W)'(n_reg) * (2*IB_W)'(isz);

    assign div_start    = (cmd == C_GEOM_START) || (cmd == C_DIV_OFF);
    assign div_dividend = (cmd == C_GEOM_START) ? chunk_reg
                        : addr_reg[CB_W-1:0] - base_reg[CB_W-1:0];

    cfla_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (isz),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg    <= ITEM_RST;
            chunk_reg   <= CHUNK_RST;
            dirty_reg   <= 1'b1;
            chunks_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd == C_GEOM_SPAN) dirty_reg <= 1'b0;
            if (cmd == C_DRAIN) chunks_reg <= '0;
            if (cmd == C_LINK && slot_last && op_reg == OP_ALLOC)
                chunks_reg <= chunks_reg + 1'b1;
            if (cmd == C_OUT) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            if (cfg_wr) begin
                dirty_reg  <= 1'b1;
                chunks_reg <= '0;
                if (cfg_sel) chunk_reg <= cfg_wdata[CB_W-1:0];
                else         item_reg  <= cfg_wdata[IB_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd)
            C_GEOM_N: begin
                n_reg <= (div_quo > CB_W'(SLOTS)) ? LW'(SLOTS) : LW'(div_quo);
            end
            C_GEOM_SPAN: span_reg <= span_prod[CB_W-1:0];
            C_ACCEPT: begin
                op_reg       <= s_tdata[OP_W-1:0];
                addr_reg     <= s_tdata[OP_W+31:OP_W];
                cnt_reg      <= '0;
                base_reg     <= '0;
                slot_reg     <= '0;
                res_addr_reg <= '0;
                owned_reg    <= 1'b0;
                status_reg   <= ST_OK;
            end
            C_SCAN_NEXT: begin
                cnt_reg  <= cnt_reg + 1'b1;
                base_reg <= base_span[TW-1:0];
            end
            C_FULL:   status_reg <= ST_FULL;
            C_NOTOWN: status_reg <= ST_NOT_OWN;
            C_MISAL:  status_reg <= ST_MISALIGN;
            C_OWNED:  owned_reg  <= sts.in_pool;
            C_LINK: begin
                if (slot_last) begin
                    slot_reg <= '0;
                    if (op_reg != OP_ALLOC) cnt_reg <= cnt_reg + 1'b1;
                end else begin
                    slot_reg <= slot_inc;
                end
            end
            C_POP_LK: prod_reg <= (IW+IB_W)'(head_q[IW-1:0]) * (IW+IB_W)'(isz);
            C_POP_WR: res_addr_reg <= res_sum[31:0];
            C_TOTAL:  total_reg <= TW'(chunks_reg) * TW'(span_reg);
            C_OUT:    m_data_reg <= {5'b0, status_reg, owned_reg, res_addr_reg};
            default: ;
        endcase
    end

    // list heads
    always_ff @(posedge aclk) begin
        if (cmd == C_LINK && slot_last) head_mem[cidx] <= '0;
        else if (cmd == C_POP_WR)       head_mem[cidx] <= link_q;
        else if (cmd == C_FREE_WR)      head_mem[cidx] <= LW'(div_quo[IW-1:0]);
        if (cmd == C_HEAD_RD) head_q <= head_mem[cidx];
    end

    // slot links
    always_ff @(posedge aclk) begin
        if (cmd == C_LINK)
            link_mem[{cidx, slot_reg[IW-1:0]}] <= slot_last ? LW'(SLOTS) : slot_inc;
        else if (cmd == C_FREE_WR)
            link_mem[{cidx, div_quo[IW-1:0]}] <= head_q;
        if (cmd == C_POP_LK) link_q <= link_mem[{cidx, head_q[IW-1:0]}];
    end

    always_comb begin
        sts.dirty     = dirty_reg;
        sts.div_done  = div_done;
        sts.cnt_eq    = cnt_reg == chunks_reg;
        sts.head_free = head_q < LW'(SLOTS);
        sts.can_new   = (n_reg != '0) && (chunks_reg < CNW'(MAX_CHUNKS));
        sts.slot_last = slot_last;
        sts.in_pool   = (span_reg != '0) && ({1'b0, addr_reg} < 33'(total_reg));
        sts.above     = {1'b0, addr_reg} >= 33'(base_span);
        sts.rem_zero  = div_rem == '0;
        sts.out_free  = !m_valid_reg || m_tready;
        sts.op        = op_reg;
    end

    assign cfg_rdata = cfg_sel ? 32'(chunk_reg) : 32'(item_reg);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    a_chunks_max: assert property (@(posedge aclk) disable iff (!aresetn)
        chunks_reg <= CNW'(MAX_CHUNKS)) else $error("chunk count overflow");
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == C_POP_WR |-> head_q < LW'(SLOTS)) else $error("popped empty list");
    a_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == C_FREE_WR |-> div_quo < CB_W'(n_reg)) else $error("freed slot out of range");

endmodule

// ----- src/cfla_ctrl.sv -----
// Allocator controller: sequences alloc, free, owner, free-all, drain and
// geometry updates through datapath commands. Depends on cfla_pkg.
module cfla_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cfla_pkg::dp_sts_t sts,
    output cfla_pkg::cmd_t    cmd
);
    import cfla_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_GEOM, S_GWAIT, S_GSPAN, S_DISP,
        S_SCAN, S_SCHK, S_NEW, S_LINK, S_HRD, S_POPLK, S_POPWR,
        S_CHK, S_FSRCH, S_FDIV, S_FWR, S_FA, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = C_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (sts.dirty) begin
                    state_next = S_GEOM;
                end else begin
                    s_tready = 1'b1;
                    if (s_tvalid) begin
                        cmd        = C_ACCEPT;
                        state_next = S_DISP;
                    end
                end
            end
            S_GEOM: begin
                cmd        = C_GEOM_START;
                state_next = S_GWAIT;
            end
            S_GWAIT: begin
                if (sts.div_done) begin
                    cmd        = C_GEOM_N;
                    state_next = S_GSPAN;
                end
            end
            S_GSPAN: begin
                cmd        = C_GEOM_SPAN;
                state_next = S_IDLE;
            end
            S_DISP: begin
                case (sts.op)
                    OP_ALLOC: state_next = S_SCAN;
                    OP_FREE, OP_OWNER: begin
                        cmd        = C_TOTAL;
                        state_next = S_CHK;
                    end
                    OP_FREE_ALL: state_next = S_FA;
                    OP_DRAIN: begin
                        cmd        = C_DRAIN;
                        state_next = S_OUT;
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_SCAN: begin
                if (sts.cnt_eq) begin
                    state_next = S_NEW;
                end else begin
                    cmd        = C_HEAD_RD;
                    state_next = S_SCHK;
                end
            end
            S_SCHK: begin
                if (sts.head_free) begin
                    cmd        = C_POP_LK;
                    state_next = S_POPWR;
                end else begin
                    cmd        = C_SCAN_NEXT;
                    state_next = S_SCAN;
                end
            end
            S_NEW: begin
                if (sts.can_new) begin
                    state_next = S_LINK;
                end else begin
                    cmd        = C_FULL;
                    state_next = S_OUT;
                end
            end
            S_LINK: begin
                cmd = C_LINK;
                if (sts.slot_last) state_next = (sts.op == OP_ALLOC) ? S_HRD : S_FA;
            end
            S_HRD: begin
                cmd        = C_HEAD_RD;
                state_next = S_POPLK;
            end
            S_POPLK: begin
                cmd        = C_POP_LK;
                state_next = S_POPWR;
            end
            S_POPWR: begin
                cmd        = C_POP_WR;
                state_next = S_OUT;
            end
            S_CHK: begin
                if (sts.op == OP_OWNER) begin
                    cmd        = C_OWNED;
                    state_next = S_OUT;
                end else if (!sts.in_pool) begin
                    cmd        = C_NOTOWN;
                    state_next = S_OUT;
                end else begin
                    state_next = S_FSRCH;
                end
            end
            S_FSRCH: begin
                if (sts.above) begin
                    cmd = C_SCAN_NEXT;
                end else begin
                    cmd        = C_DIV_OFF;
                    state_next = S_FDIV;
                end
            end
            S_FDIV: begin
                if (sts.div_done) begin
                    if (sts.rem_zero) begin
                        cmd        = C_HEAD_RD;
                        state_next = S_FWR;
                    end else begin
                        cmd        = C_MISAL;
                        state_next = S_OUT;
                    end
                end
            end
            S_FWR: begin
                cmd        = C_FREE_WR;
                state_next = S_OUT;
            end
            S_FA: begin
                state_next = sts.cnt_eq ? S_OUT : S_LINK;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd        = C_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_accept_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == S_DISP) else $error("accept not dispatched");
    a_ready_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.dirty) else $error("ready with stale geometry");
    a_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == C_OUT |=> state_reg == S_IDLE) else $error("result not followed by idle");

endmodule
